// ===== design/frs_pkg.sv =====
// package for the fpu register stack: request and response structs,
// operation and fault codes, stack geometry and slot arithmetic helpers
// no dependencies
package frs_pkg;

  localparam int unsigned StackDepth = 8;
  localparam int unsigned PtrW = (StackDepth > 1) ? $clog2(StackDepth) : 1;
  localparam int unsigned IdxW = 3;
  // wide enough for top + index and for the three low bits of top
  localparam int unsigned SumW = ((PtrW > IdxW) ? PtrW : IdxW) + 1;

  localparam int unsigned MantW = 64;
  localparam int unsigned SexpW = 16;
  localparam int unsigned StatW = 16;
  localparam int unsigned FaultW = 2;

  typedef logic [PtrW-1:0] ptr_t;

  typedef enum logic [2:0] {
    OpPush    = 3'd0,
    OpPop     = 3'd1,
    OpRead    = 3'd2,
    OpWrite   = 3'd3,
    OpSetCode = 3'd4,
    OpStatus  = 3'd5
  } op_e;

  localparam logic [FaultW-1:0] FaultNone  = 2'd0;
  localparam logic [FaultW-1:0] FaultEmpty = 2'd1;
  localparam logic [FaultW-1:0] FaultFull  = 2'd2;

  typedef struct packed {
    logic [2:0]       operation;
    logic [IdxW-1:0]  stack_index;
    logic [MantW-1:0] in_mantissa;
    logic [SexpW-1:0] in_sign_exponent;
    logic [StatW-1:0] status_in;
  } req_t;

  typedef struct packed {
    logic [MantW-1:0]  out_mantissa;
    logic [SexpW-1:0]  out_sign_exponent;
    logic [StatW-1:0]  status_word;
    logic [FaultW-1:0] fault;
  } rsp_t;

  typedef struct packed {
    logic [SexpW-1:0] sign_exponent;
    logic [MantW-1:0] mantissa;
  } entry_t;

  // (top + i) mod depth, by repeated conditional subtract on a narrow value
  function automatic ptr_t slot_of(ptr_t top, logic [IdxW-1:0] idx);
    logic [SumW-1:0] v;
    v = SumW'(top) + SumW'(idx);
    for (int k = 0; k < 8; k++) begin
      if (v >= SumW'(StackDepth)) begin
        v = v - SumW'(StackDepth);
      end
    end
    return v[PtrW-1:0];
  endfunction

  function automatic ptr_t ptr_dec(ptr_t p);
    return (p == '0) ? PtrW'(StackDepth - 1) : ptr_t'(p - 1'b1);
  endfunction

  function automatic ptr_t ptr_inc(ptr_t p);
    return (p == PtrW'(StackDepth - 1)) ? '0 : ptr_t'(p + 1'b1);
  endfunction

endpackage

// ===== design/frs_entry_ram.sv =====
// entry storage of the register stack: single-port synchronous ram,
// registered read; uses frs_pkg
module frs_entry_ram (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic                we_i,
  input  frs_pkg::ptr_t       addr_i,
  input  frs_pkg::entry_t     wdata_i,
  output frs_pkg::entry_t     rdata_o
);

  frs_pkg::entry_t mem_q [frs_pkg::StackDepth];
  frs_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/frs_out_queue.sv =====
// two-entry response queue between the stack core and the output channel
// uses frs_pkg
module frs_out_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  frs_pkg::rsp_t data_i,
  output logic          full_o,
  output logic          valid_o,
  input  logic          ready_i,
  output frs_pkg::rsp_t data_o
);

  frs_pkg::rsp_t buf_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       pop;

  assign pop     = valid_o & ready_i;
  assign valid_o = (count_q != 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign data_o  = buf_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push_i) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== design/fpu_register_stack.sv =====
// fpu register stack: push, write, set code, read status and any faulting
// request put their response into the response queue at accept; a pop or
// read of a valid entry passes the entry ram read register, then the queue
// throughput: one request per cycle while the response queue has room, except
// that a valid pop or read blocks the next request until its data is queued
// reset clears top, condition code, valid marks and the response queue;
// entry data stays unset until pushed; uses frs_pkg, frs_entry_ram,
// frs_out_queue
module fpu_register_stack (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  frs_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output frs_pkg::rsp_t out_rsp_o
);

  // one-hot sequencer: idle, or waiting for the entry ram read data
  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StRead = 2'b10
  } state_e;

  state_e state_q, state_d;

  // architectural state outside the ram
  frs_pkg::ptr_t                      top_q, top_d;
  logic [3:0]                         cc_q, cc_d;
  logic [frs_pkg::StackDepth-1:0]     valid_q, valid_d;

  // entry ram access
  logic            ram_en, ram_we;
  frs_pkg::ptr_t   ram_addr;
  frs_pkg::entry_t ram_wdata, ram_rdata;

  // response queue
  logic          q_push, q_full;
  frs_pkg::rsp_t q_data, imm_rsp;

  logic                     accept;
  logic                     go_read;
  frs_pkg::ptr_t            push_slot, idx_slot;
  logic [frs_pkg::SumW-1:0] top_ext;

  // a new request only in idle and with room in the queue
  assign in_ready_o = (state_q == StIdle) & ~q_full;
  assign accept     = in_valid_i & in_ready_o;

  assign push_slot = frs_pkg::ptr_dec(top_q);
  assign idx_slot  = frs_pkg::slot_of(top_q, in_req_i.stack_index);
  assign top_ext   = frs_pkg::SumW'(top_q);

  assign ram_wdata.sign_exponent = in_req_i.in_sign_exponent;
  assign ram_wdata.mantissa      = in_req_i.in_mantissa;

  always_comb begin
    top_d    = top_q;
    cc_d     = cc_q;
    valid_d  = valid_q;
    ram_en   = 1'b0;
    ram_we   = 1'b0;
    ram_addr = idx_slot;
    go_read  = 1'b0;
    imm_rsp  = '0;

    if (accept) begin
      unique case (in_req_i.operation)
        frs_pkg::OpPush: begin
          // top moves even when the new top entry is occupied
          top_d    = push_slot;
          ram_addr = push_slot;
          if (valid_q[push_slot]) begin
            imm_rsp.fault = frs_pkg::FaultFull;
          end else begin
            valid_d[push_slot] = 1'b1;
            ram_en = 1'b1;
            ram_we = 1'b1;
          end
        end
        frs_pkg::OpPop: begin
          ram_addr = top_q;
          if (!valid_q[top_q]) begin
            imm_rsp.fault = frs_pkg::FaultEmpty;
          end else begin
            // value comes back from the ram next cycle
            valid_d[top_q] = 1'b0;
            top_d   = frs_pkg::ptr_inc(top_q);
            ram_en  = 1'b1;
            go_read = 1'b1;
          end
        end
        frs_pkg::OpRead: begin
          if (!valid_q[idx_slot]) begin
            imm_rsp.fault = frs_pkg::FaultEmpty;
          end else begin
            ram_en  = 1'b1;
            go_read = 1'b1;
          end
        end
        frs_pkg::OpWrite: begin
          if (!valid_q[idx_slot]) begin
            imm_rsp.fault = frs_pkg::FaultEmpty;
          end else begin
            ram_en = 1'b1;
            ram_we = 1'b1;
          end
        end
        frs_pkg::OpSetCode: begin
          // status bit 14 -> code bit 3, bits 10..8 -> code bits 2..0
          cc_d = {in_req_i.status_in[14], in_req_i.status_in[10:8]};
        end
        frs_pkg::OpStatus: begin
          // only the low three bits of top are packed
          imm_rsp.status_word = {1'b0, cc_q[3], top_ext[2:0], cc_q[2:0], 8'h00};
        end
        default: begin
          // unused operation codes: no state change, all-zero response
        end
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (go_read) state_d = StRead;
      StRead: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // response from the ram read, or the immediate one at accept
  always_comb begin
    q_data = imm_rsp;
    q_push = accept & ~go_read;
    if (state_q == StRead) begin
      q_data = '0;
      q_data.out_mantissa      = ram_rdata.mantissa;
      q_data.out_sign_exponent = ram_rdata.sign_exponent;
      q_data.fault             = frs_pkg::FaultNone;
      q_push = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      top_q   <= '0;
      cc_q    <= '0;
      valid_q <= '0;
    end else begin
      state_q <= state_d;
      top_q   <= top_d;
      cc_q    <= cc_d;
      valid_q <= valid_d;
    end
  end

  frs_entry_ram u_entry_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // queue space is checked at accept, and no request is taken while in
  // StRead, so the read response always finds a free slot
  frs_out_queue u_out_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_data),
    .full_o  (q_full),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_rsp_o)
  );

endmodule
